// File: sv/pf8_pkg.sv
// Shared types, codes and symbol conversion for the 8x8 pair cipher.
// No dependencies; imported by playfair_8x8_pair_cipher.
package pf8_pkg;

    localparam int CELLS  = 64;
    localparam int IDX_W  = 6;
    localparam int FILL_W = 7;

    // Item modes
    localparam logic [2:0] MODE_BEGIN = 3'd0;
    localparam logic [2:0] MODE_KEY   = 3'd1;
    localparam logic [2:0] MODE_SEAL  = 3'd2;
    localparam logic [2:0] MODE_ENC   = 3'd3;
    localparam logic [2:0] MODE_DEC   = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd1;
    localparam logic [1:0] STATUS_UNSEALED   = 2'd2;

    // ASCII anchors of the alphabet
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // Alphabet index bases
    localparam logic [5:0] IDX_DIGIT = 6'd26;
    localparam logic [5:0] IDX_AT    = 6'd36;
    localparam logic [5:0] IDX_AMP   = 6'd37;
    localparam logic [5:0] IDX_UPPER = 6'd38;
    localparam logic [5:0] IDX_LAST  = 6'd63;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] symbol_a;
        logic [7:0] symbol_b;
        logic       wrap_in;
    } pf8_in_t;

    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic       wrap_out;
        logic [1:0] status;
    } pf8_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEAL,
        ST_LOOKUP,
        ST_FETCH,
        ST_REPLY
    } pf8_state_t;

    // Top bit set: symbol outside the alphabet
    function automatic logic [6:0] index_of(input logic [7:0] ch);
        logic [6:0] r;
        r = {1'b1, 6'd0};
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            r = {1'b0, 6'(ch - CH_LOWER_A)};
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            r = {1'b0, IDX_DIGIT + 6'(ch - CH_DIGIT_0)};
        end else if (ch == CH_AT) begin
            r = {1'b0, IDX_AT};
        end else if (ch == CH_AMP) begin
            r = {1'b0, IDX_AMP};
        end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            r = {1'b0, IDX_UPPER + 6'(ch - CH_UPPER_A)};
        end
        return r;
    endfunction

    function automatic logic [7:0] ascii_of(input logic [5:0] idx);
        logic [7:0] r;
        if (idx < IDX_DIGIT) begin
            r = CH_LOWER_A + {2'b00, idx};
        end else if (idx < IDX_AT) begin
            r = CH_DIGIT_0 + {2'b00, 6'(idx - IDX_DIGIT)};
        end else if (idx == IDX_AT) begin
            r = CH_AT;
        end else if (idx == IDX_AMP) begin
            r = CH_AMP;
        end else begin
            r = CH_UPPER_A + {2'b00, 6'(idx - IDX_UPPER)};
        end
        return r;
    endfunction

endpackage

// File: sv/playfair_8x8_pair_cipher.sv
// Pair cipher on an 8x8 square: key loading, sealing and pair encrypt/decrypt.
// Depends on pf8_pkg for item types, codes and symbol conversion.
//
//   channel   ports                        direction   beat
//   input     s_valid, s_ready, s_data     in          one item (mode, pair, wrap)
//   result    m_valid, m_ready, m_data     out         one result per item
//
// Begin, key, error, equal-pair and spare-mode items, and a repeated seal, pass
// through the EXEC and REPLY states. Other pairs add a position lookup then a
// square read, each a registered read of a single-port-written memory. A seal of
// an unsealed square walks all 64 alphabet entries, one a cycle. One item is in
// flight at a time; a held output result blocks its reply, not the next accept.
// aresetn (synchronous) clears control state and the used marks; the square
// and position memories hold nothing valid until keyed and sealed.
module playfair_8x8_pair_cipher (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pf8_pkg::pf8_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pf8_pkg::pf8_out_t m_data
);
    import pf8_pkg::*;

    pf8_state_t state_reg, state_next;
    pf8_in_t    item_reg, item_next;
    pf8_out_t   result_reg, result_next;
    pf8_out_t   out_reg, out_next;
    logic       m_valid_reg, m_valid_next;

    logic [CELLS-1:0]  used_marks_reg, used_marks_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic              sealed_reg, sealed_next;
    logic [IDX_W-1:0]  seal_idx_reg, seal_idx_next;
    logic              wrap_reg, wrap_next;

    // Memories
    logic [IDX_W-1:0] square_mem [CELLS];
    logic [IDX_W-1:0] position_mem [CELLS];
    logic [IDX_W-1:0] pos_rd_a_reg, pos_rd_b_reg;
    logic [IDX_W-1:0] sq_rd_a_reg, sq_rd_b_reg;
    logic [IDX_W-1:0] sq_raddr_a, sq_raddr_b;

    logic             place_en;
    logic [IDX_W-1:0] place_idx;

    // Item decode
    logic [6:0]       code_a, code_b;
    logic             bad_a, bad_b;
    logic [IDX_W-1:0] ia, ib;

    assign code_a = index_of(item_reg.symbol_a);
    assign code_b = index_of(item_reg.symbol_b);
    assign bad_a  = code_a[6];
    assign bad_b  = code_b[6];
    assign ia     = code_a[IDX_W-1:0];
    assign ib     = code_b[IDX_W-1:0];

    logic pair_direct;
    assign pair_direct = bad_a || bad_b || !sealed_reg || (ia == ib);

    // Geometry of the looked-up pair
    logic [2:0] r1, c1, r2, c2, a1, a2, n1, n2, step;
    logic       rect, row_line, forward, edge_hit, enc, shift_fwd;

    always_comb begin
        r1        = pos_rd_a_reg[5:3];
        c1        = pos_rd_a_reg[2:0];
        r2        = pos_rd_b_reg[5:3];
        c2        = pos_rd_b_reg[2:0];
        rect      = (r1 != r2) && (c1 != c2);
        row_line  = (r1 == r2);
        a1        = row_line ? c1 : r1;
        a2        = row_line ? c2 : r2;
        forward   = a1 < a2;
        edge_hit  = forward ? (a2 == 3'd7) : (a2 == 3'd0);
        enc       = (item_reg.mode == MODE_ENC);
        shift_fwd = enc || (item_reg.wrap_in && edge_hit);
        // step +1 when shifting with a forward pair or against a backward one, else -1 mod 8
        step      = (shift_fwd == forward) ? 3'd1 : 3'd7;
        n1        = a1 + step;
        n2        = a2 + step;
        if (rect) begin
            sq_raddr_a = {r1, c2};
            sq_raddr_b = {r2, c1};
        end else if (row_line) begin
            sq_raddr_a = {r1, n1};
            sq_raddr_b = {r2, n2};
        end else begin
            sq_raddr_a = {n1, c1};
            sq_raddr_b = {n2, c2};
        end
    end

    // Memory ports: one write each, two registered reads each
    always_ff @(posedge aclk) begin
        if (place_en) begin
            square_mem[fill_count_reg[IDX_W-1:0]] <= place_idx;
            position_mem[place_idx]               <= fill_count_reg[IDX_W-1:0];
        end
        pos_rd_a_reg <= position_mem[ia];
        pos_rd_b_reg <= position_mem[ib];
        sq_rd_a_reg  <= square_mem[sq_raddr_a];
        sq_rd_b_reg  <= square_mem[sq_raddr_b];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (item_reg.mode)
                    MODE_SEAL: state_next = sealed_reg ? ST_REPLY : ST_SEAL;
                    MODE_ENC,
                    MODE_DEC:  state_next = pair_direct ? ST_REPLY : ST_LOOKUP;
                    default:   state_next = ST_REPLY;
                endcase
            end
            ST_SEAL: begin
                if (seal_idx_reg == IDX_LAST) begin
                    state_next = ST_REPLY;
                end
            end
            ST_LOOKUP: state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_REPLY;
            ST_REPLY: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        item_next       = item_reg;
        result_next     = result_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        used_marks_next = used_marks_reg;
        fill_count_next = fill_count_reg;
        sealed_next     = sealed_reg;
        seal_idx_next   = seal_idx_reg;
        wrap_next       = wrap_reg;
        place_en        = 1'b0;
        place_idx       = ia;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            ST_EXEC: begin
                result_next = '0;
                case (item_reg.mode)
                    MODE_BEGIN: begin
                        used_marks_next = '0;
                        fill_count_next = '0;
                        sealed_next     = 1'b0;
                    end
                    MODE_KEY: begin
                        if (bad_a) begin
                            result_next.status = STATUS_BAD_SYMBOL;
                        end else if (!sealed_reg && !used_marks_reg[ia]) begin
                            place_en = 1'b1;
                        end
                    end
                    MODE_SEAL: begin
                        seal_idx_next = '0;
                    end
                    MODE_ENC,
                    MODE_DEC: begin
                        if (bad_a || bad_b) begin
                            result_next.status = STATUS_BAD_SYMBOL;
                        end else if (!sealed_reg) begin
                            result_next.status = STATUS_UNSEALED;
                        end else if (ia == ib) begin
                            result_next.out_a = ascii_of(ia);
                            result_next.out_b = ascii_of(ib);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SEAL: begin
                place_idx     = seal_idx_reg;
                place_en      = !used_marks_reg[seal_idx_reg];
                seal_idx_next = seal_idx_reg + 6'd1;
                if (seal_idx_reg == IDX_LAST) begin
                    sealed_next = 1'b1;
                end
            end
            ST_LOOKUP: begin
                // only the second symbol of a line pair can cross an edge
                wrap_next = enc && !rect && edge_hit;
            end
            ST_FETCH: begin
                result_next.out_a    = ascii_of(sq_rd_a_reg);
                result_next.out_b    = ascii_of(sq_rd_b_reg);
                result_next.wrap_out = wrap_reg;
                result_next.status   = STATUS_OK;
            end
            ST_REPLY: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = result_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (place_en) begin
            used_marks_next[place_idx] = 1'b1;
            if (fill_count_reg < FILL_W'(CELLS)) begin
                fill_count_next = fill_count_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            used_marks_reg <= '0;
            fill_count_reg <= '0;
            sealed_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            used_marks_reg <= used_marks_next;
            fill_count_reg <= fill_count_next;
            sealed_reg     <= sealed_next;
        end
        item_reg     <= item_next;
        result_reg   <= result_next;
        out_reg      <= out_next;
        seal_idx_reg <= seal_idx_next;
        wrap_reg     <= wrap_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Checks
    a_fill_tracks_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_marks_reg) == int'(fill_count_reg))
        else $error("fill count differs from number of used marks");

    a_sealed_full: assert property (@(posedge aclk) disable iff (!aresetn)
        sealed_reg |-> (fill_count_reg == FILL_W'(CELLS)))
        else $error("square sealed but not full");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in flight");

    a_seal_ends_sealed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEAL && seal_idx_reg == IDX_LAST) |=> sealed_reg)
        else $error("seal walk finished without sealing");

endmodule

// File: tb/tb_playfair_8x8_pair_cipher.sv
// Self-checking testbench for playfair_8x8_pair_cipher: directed table, then key sessions.
// Every result is checked against a typed table value or a local cipher predictor.
// Depends on pf8_pkg and the playfair_8x8_pair_cipher RTL only.
`timescale 1ns / 100ps

module tb_playfair_8x8_pair_cipher;
    import pf8_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 11;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 100;
    localparam int RANDOM_PER_PHASE = 262;
    localparam int N_DIRECTED       = 27;
    localparam int EXP_DEPTH        = 8;

    // Modes that the block ignores
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam pf8_out_t RES_QUIET    = '{8'h00, 8'h00, 1'b0, STATUS_OK};
    localparam pf8_out_t RES_BAD      = '{8'h00, 8'h00, 1'b0, STATUS_BAD_SYMBOL};
    localparam pf8_out_t RES_UNSEALED = '{8'h00, 8'h00, 1'b0, STATUS_UNSEALED};

    typedef struct {
        pf8_in_t  item;
        bit       typed;
        pf8_out_t want;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pf8_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pf8_out_t m_data;

    // Predictor state
    string      alphabet = "abcdefghijklmnopqrstuvwxyz0123456789@&ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    logic [7:0] sym_char [64];
    logic [6:0] char_idx [256];
    logic [5:0] cell_sym [64];
    logic [5:0] sym_cell [64];
    bit         sym_used [64];
    logic [6:0] fill_level;
    bit         square_sealed;

    // Expected results in order of acceptance
    pf8_out_t expected_replies [EXP_DEPTH];
    int       exp_wr = 0;
    int       exp_rd = 0;
    pf8_out_t last_reply;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_go      = 1'b0;
    int hold_count   = 0;

    int fail_count  = 0;
    int n_items     = 0;
    int n_checked   = 0;
    int n_sessions  = 0;
    int n_seals     = 0;
    int n_pairs_ok  = 0;
    int n_wraps     = 0;
    int n_rejected  = 0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{'{MODE_ENC,      "a",   "b",   1'b0}, 1'b1, RES_UNSEALED},
        '{'{MODE_DEC,      8'h21, "b",   1'b0}, 1'b1, RES_BAD},
        '{'{MODE_SPARE_HI, 8'hFF, 8'hFF, 1'b1}, 1'b1, RES_QUIET},
        '{'{MODE_SPARE_LO, "q",   "r",   1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_KEY,      8'h23, 8'h00, 1'b0}, 1'b1, RES_BAD},
        '{'{MODE_SEAL,     8'h00, 8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_ENC,      "a",   "h",   1'b0}, 1'b0, RES_QUIET},
        '{'{MODE_ENC,      "h",   "a",   1'b0}, 1'b0, RES_QUIET},
        '{'{MODE_ENC,      "a",   "S",   1'b0}, 1'b0, RES_QUIET},
        '{'{MODE_DEC,      "b",   "a",   1'b1}, 1'b0, RES_QUIET},
        '{'{MODE_DEC,      "a",   "c",   1'b1}, 1'b0, RES_QUIET},
        '{'{MODE_DEC,      "a",   "h",   1'b0}, 1'b0, RES_QUIET},
        '{'{MODE_ENC,      "a",   "j",   1'b0}, 1'b0, RES_QUIET},
        '{'{MODE_ENC,      "Z",   "Z",   1'b0}, 1'b1, '{"Z", "Z", 1'b0, STATUS_OK}},
        '{'{MODE_ENC,      8'h00, "a",   1'b0}, 1'b1, RES_BAD},
        '{'{MODE_BEGIN,    8'h00, 8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_DEC,      "a",   "b",   1'b1}, 1'b1, RES_UNSEALED},
        '{'{MODE_KEY,      "Z",   8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_KEY,      "Z",   8'hFF, 1'b1}, 1'b1, RES_QUIET},
        '{'{MODE_KEY,      "&",   8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_KEY,      "@",   8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_KEY,      "9",   8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_SEAL,     8'h00, 8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_SEAL,     8'hFF, 8'hFF, 1'b1}, 1'b1, RES_QUIET},
        '{'{MODE_KEY,      "q",   8'h00, 1'b0}, 1'b1, RES_QUIET},
        '{'{MODE_DEC,      "&",   "9",   1'b1}, 1'b0, RES_QUIET},
        '{'{MODE_ENC,      "0",   "z",   1'b0}, 1'b0, RES_QUIET}
    };

    playfair_8x8_pair_cipher i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    initial begin
        #(6_000_000);
        $display("** playfair_8x8_pair_cipher: FAILED **");
        $finish;
    end

    function automatic void place_symbol(input logic [5:0] idx);
        cell_sym[fill_level[5:0]] = idx;
        sym_cell[idx] = fill_level[5:0];
        sym_used[idx] = 1'b1;
        if (fill_level < 7'd64) begin
            fill_level = fill_level + 7'd1;
        end
    endfunction

    function automatic pf8_out_t cipher_step(input pf8_in_t it);
        pf8_out_t   r;
        logic [6:0] ia, ib;
        logic [5:0] p1, p2;
        logic [2:0] r1, c1, r2, c2, a1, a2, n1, n2;
        bit         row_line, forward, at_edge;
        r  = RES_QUIET;
        ia = char_idx[it.symbol_a];
        ib = char_idx[it.symbol_b];
        case (it.mode)
            MODE_BEGIN: begin
                foreach (sym_used[i]) sym_used[i] = 1'b0;
                fill_level    = '0;
                square_sealed = 1'b0;
            end
            MODE_KEY: begin
                if (ia[6]) begin
                    r.status = STATUS_BAD_SYMBOL;
                end else if (!square_sealed && !sym_used[ia[5:0]]) begin
                    place_symbol(ia[5:0]);
                end
            end
            MODE_SEAL: begin
                if (!square_sealed) begin
                    for (int i = 0; i < CELLS; i++) begin
                        if (!sym_used[i]) place_symbol(6'(i));
                    end
                    square_sealed = 1'b1;
                end
            end
            MODE_ENC, MODE_DEC: begin
                if (ia[6] || ib[6]) begin
                    r.status = STATUS_BAD_SYMBOL;
                end else if (!square_sealed) begin
                    r.status = STATUS_UNSEALED;
                end else if (ia == ib) begin
                    r.out_a = sym_char[ia[5:0]];
                    r.out_b = sym_char[ib[5:0]];
                end else begin
                    p1 = sym_cell[ia[5:0]];
                    p2 = sym_cell[ib[5:0]];
                    r1 = p1[5:3];
                    c1 = p1[2:0];
                    r2 = p2[5:3];
                    c2 = p2[2:0];
                    if (r1 != r2 && c1 != c2) begin
                        // rectangle: swap columns
                        r.out_a = sym_char[cell_sym[{r1, c2}]];
                        r.out_b = sym_char[cell_sym[{r2, c1}]];
                    end else begin
                        row_line = (r1 == r2);
                        a1       = row_line ? c1 : r1;
                        a2       = row_line ? c2 : r2;
                        forward  = (a1 < a2);
                        at_edge  = forward ? (a2 == 3'd7) : (a2 == 3'd0);
                        if (it.mode == MODE_ENC || (it.wrap_in && at_edge)) begin
                            n1 = forward ? a1 + 3'd1 : a1 - 3'd1;
                            n2 = forward ? a2 + 3'd1 : a2 - 3'd1;
                            r.wrap_out = (it.mode == MODE_ENC) && at_edge;
                        end else begin
                            // step back; a malformed pair simply wraps
                            n1 = forward ? a1 - 3'd1 : a1 + 3'd1;
                            n2 = forward ? a2 - 3'd1 : a2 + 3'd1;
                        end
                        if (row_line) begin
                            r.out_a = sym_char[cell_sym[{r1, n1}]];
                            r.out_b = sym_char[cell_sym[{r2, n2}]];
                        end else begin
                            r.out_a = sym_char[cell_sym[{n1, c1}]];
                            r.out_b = sym_char[cell_sym[{n2, c2}]];
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one beat; predict it once the block takes it.
    task automatic offer(input pf8_in_t it, input bit typed, input pf8_out_t want);
        pf8_out_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = cipher_step(it);
        expected_replies[exp_wr % EXP_DEPTH] = typed ? want : predicted;
        exp_wr++;
        last_reply = predicted;
        n_items++;
        if (predicted.status != STATUS_OK) begin
            n_rejected++;
        end else if (it.mode == MODE_ENC || it.mode == MODE_DEC) begin
            n_pairs_ok++;
            n_wraps += predicted.wrap_out;
        end
        if (it.mode == MODE_SEAL) n_seals++;
    endtask

    function automatic logic [7:0] pick_symbol();
        return ($urandom_range(19) == 0) ? 8'($urandom) : sym_char[$urandom_range(63)];
    endfunction

    // Mostly pairs that share a row or column of the current square.
    function automatic pf8_in_t make_pair();
        pf8_in_t    it;
        logic [5:0] ia, ib, home_pos;
        int         shape;
        ia       = 6'($urandom_range(63));
        home_pos = sym_cell[ia];
        shape    = $urandom_range(9);
        if (shape < 3) begin
            ib = cell_sym[{home_pos[5:3], 3'($urandom_range(7))}];
        end else if (shape < 6) begin
            ib = cell_sym[{3'($urandom_range(7)), home_pos[2:0]}];
        end else if (shape == 6) begin
            ib = ia;
        end else begin
            ib = 6'($urandom_range(63));
        end
        it.mode     = ($urandom_range(1) != 0) ? MODE_ENC : MODE_DEC;
        it.symbol_a = sym_char[ia];
        it.symbol_b = sym_char[ib];
        it.wrap_in  = 1'($urandom_range(1));
        if ($urandom_range(14) == 0) it.symbol_a = 8'($urandom);
        if ($urandom_range(14) == 0) it.symbol_b = 8'($urandom);
        return it;
    endfunction

    // One key session: begin, keys, usually a seal, then pairs with some noise.
    task automatic run_session();
        pf8_in_t it;
        int      n_keys;
        int      n_pairs;
        n_sessions++;
        it = '{MODE_BEGIN, 8'($urandom), 8'($urandom), 1'($urandom)};
        offer(it, 1'b0, RES_QUIET);
        n_keys = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(10);
        repeat (n_keys) begin
            it = '{MODE_KEY, pick_symbol(), 8'($urandom), 1'($urandom)};
            offer(it, 1'b0, RES_QUIET);
        end
        if ($urandom_range(9) != 0) begin
            it = '{MODE_SEAL, 8'($urandom), 8'($urandom), 1'($urandom)};
            offer(it, 1'b0, RES_QUIET);
            if ($urandom_range(7) == 0) offer(it, 1'b0, RES_QUIET);
        end
        if ($urandom_range(7) == 0) begin
            it = '{MODE_KEY, pick_symbol(), 8'($urandom), 1'($urandom)};
            offer(it, 1'b0, RES_QUIET);
        end
        n_pairs = $urandom_range(4, 20);
        repeat (n_pairs) begin
            if ($urandom_range(11) == 0) begin
                it = '{3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)};
            end else begin
                it = make_pair();
            end
            offer(it, 1'b0, RES_QUIET);
            // feed an encrypted pair straight back for decryption
            if (it.mode == MODE_ENC && last_reply.status == STATUS_OK
                    && $urandom_range(2) == 0) begin
                it = '{MODE_DEC, last_reply.out_a, last_reply.out_b, last_reply.wrap_out};
                offer(it, 1'b0, RES_QUIET);
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        target       = n_items + RANDOM_PER_PHASE;
        while (n_items < target) run_session();
    endtask

    // Result side: random stalls, plus one long hold-off once released.
    always @(negedge aclk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            m_ready    <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pf8_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                $error("result beat with nothing expected: %h", m_data);
                fail_count++;
            end else begin
                want = expected_replies[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_checked++;
                if (m_data.out_a !== want.out_a) begin
                    $error("out_a: expected %h, got %h", want.out_a, m_data.out_a);
                    fail_count++;
                end
                if (m_data.out_b !== want.out_b) begin
                    $error("out_b: expected %h, got %h", want.out_b, m_data.out_b);
                    fail_count++;
                end
                if (m_data.wrap_out !== want.wrap_out) begin
                    $error("wrap_out: expected %b, got %b", want.wrap_out, m_data.wrap_out);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        foreach (char_idx[i]) char_idx[i] = 7'h40;
        for (int i = 0; i < CELLS; i++) begin
            sym_char[i]           = alphabet[i];
            char_idx[alphabet[i]] = {1'b0, 6'(i)};
            cell_sym[i]           = '0;
            sym_cell[i]           = '0;
            sym_used[i]           = 1'b0;
        end
        fill_level    = '0;
        square_sealed = 1'b0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // hold the result side off while the sender keeps pushing
        hold_go = 1'b1;
        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(20, 20);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items over %0d key sessions with %0d seals; %0d results checked.",
                 n_items, n_sessions, n_seals, n_checked);
        $display("Pairs ciphered: %0d (%0d edge wraps); items rejected with an error: %0d.",
                 n_pairs_ok, n_wraps, n_rejected);
        if (fail_count == 0) begin
            $display("** playfair_8x8_pair_cipher: PASSED **");
        end else begin
            $display("** playfair_8x8_pair_cipher: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
sv/pf8_pkg.sv
sv/playfair_8x8_pair_cipher.sv
tb/tb_playfair_8x8_pair_cipher.sv
